// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// each macro expects i_clk (DPD_ASSERT also i_rst_n) in its scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define DPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// property checked at every edge, reset included
`define DPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/dpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpd_pkg
// Types, codes and helpers for the debug link packet deframer.
// ----------------------------------------------------------------------------
package dpd_pkg;

    // receive buffer size in bytes; at most MESSAGE_BUFFER-1 bytes are kept
    localparam int MESSAGE_BUFFER = 2048;
    localparam int KEPT_W         = $clog2(MESSAGE_BUFFER);
    localparam logic [KEPT_W-1:0] KEEP_LIMIT = KEPT_W'(MESSAGE_BUFFER - 1);

    // link characters
    localparam logic [7:0] CH_BREAK  = 8'h03;
    localparam logic [7:0] CH_START  = 8'h24;  // '$'
    localparam logic [7:0] CH_END    = 8'h23;  // '#'
    localparam logic [7:0] CH_ESCAPE = 8'h7d;  // '}'
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // parser phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } t_phase;

    // result kind
    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_END     = 2'd1,
        EV_BREAK   = 2'd2
    } t_event_kind;

    // reply to send at packet end
    typedef enum logic [1:0] {
        ACK_NONE = 2'd0,
        ACK_POS  = 2'd1,
        ACK_NEG  = 2'd2
    } t_ack;

    // one result word
    typedef struct packed {
        t_event_kind event_kind;
        logic [7:0]  payload_byte;
        logic        checksum_good;
        t_ack        reply_ack;
        logic [10:0] payload_length;
        logic        truncated;
        logic        last;
    } t_result;

    // hex digit decode: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

endpackage

// ===== rtl/debug_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// debug_packet_deframer
// Byte-serial deframer for a remote debug link: finds '$' ... '#xx' packets,
// undoes '}' escapes, checks the 8-bit sum and reports break requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry one received byte (i_rx_byte) per
//   word. A word is taken at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry one result word: a decoded
//   payload byte, a packet end (verdict, ack to send, kept length, truncated)
//   or a break request. Framing bytes and idle noise give no result word.
//   Each result is registered. Throughput: one byte per cycle while o_stall
//   is low; the parser state updates in the same cycle the byte is taken,
//   so back-to-back bytes need no gap.
//   A two-entry output buffer (result register plus skid register) sits
//   between the channels: bytes keep flowing while one result waits, and
//   o_stall rises only when both entries hold results; it depends on a
//   register, never on i_stall.
//   Reset (i_rst_n low, synchronous) empties the buffer, returns the parser
//   to idle and clears no-ack mode. i_cfg_wr_en writes no-ack mode; write it
//   only while the block is idle.
// ----------------------------------------------------------------------------
module debug_packet_deframer
    import dpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    // received bytes
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result words
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_checksum_good,
    output logic [1:0]  o_reply_ack,
    output logic [10:0] o_payload_length,
    output logic        o_truncated,
    output logic        o_last
);

    // parser state
    t_phase             r_phase,  n_phase;
    logic [7:0]         r_sum,    n_sum;
    logic [4:0]         r_high,   n_high;
    logic [KEPT_W-1:0]  r_kept,   n_kept;
    logic               r_ovf,    n_ovf;
    logic               r_no_ack;

    // output buffer
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    t_result            r_out, n_out;
    t_result            r_skid, n_skid;

    logic               accept;
    logic               res_valid;
    t_result            res;
    logic               keep_req;
    logic [7:0]         keep_byte;
    logic [4:0]         lo_digit;
    logic               good;

    assign accept   = i_valid && !r_skid_valid;
    assign o_stall  = r_skid_valid;
    assign lo_digit = hex_value(i_rx_byte);
    assign good     = r_high[4] && lo_digit[4] && ({r_high[3:0], lo_digit[3:0]} == r_sum);

    // per-byte parser
    always_comb begin
        n_phase   = r_phase;
        n_sum     = r_sum;
        n_high    = r_high;
        n_kept    = r_kept;
        n_ovf     = r_ovf;
        keep_req  = 1'b0;
        keep_byte = i_rx_byte;
        res_valid = 1'b0;
        res       = '0;
        res.event_kind = EV_PAYLOAD;
        res.reply_ack  = ACK_NONE;

        case (r_phase)
            PH_BODY: begin
                if (i_rx_byte == CH_END) begin
                    n_phase = PH_HEX1;
                end else begin
                    n_sum = r_sum + i_rx_byte;
                    if (i_rx_byte == CH_ESCAPE) begin
                        n_phase = PH_ESC;
                    end else begin
                        keep_req = 1'b1;
                    end
                end
            end
            PH_ESC: begin
                keep_req = 1'b1;
                if (i_rx_byte == CH_END) begin
                    // escape right before the end mark stays a literal '}'
                    n_phase   = PH_HEX1;
                    keep_byte = CH_ESCAPE;
                end else begin
                    n_sum     = r_sum + i_rx_byte;
                    n_phase   = PH_BODY;
                    keep_byte = i_rx_byte ^ ESC_XOR;
                end
            end
            PH_HEX1: begin
                n_high  = lo_digit;
                n_phase = PH_HEX2;
            end
            PH_HEX2: begin
                res_valid          = 1'b1;
                res.event_kind     = EV_END;
                res.checksum_good  = good;
                res.reply_ack      = good ? (r_no_ack ? ACK_NONE : ACK_POS) : ACK_NEG;
                res.payload_length = 11'(r_kept);
                res.truncated      = r_ovf;
                res.last           = 1'b1;
                n_phase            = PH_IDLE;
                n_high             = 5'd0;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_rx_byte == CH_BREAK) begin
                    res_valid      = 1'b1;
                    res.event_kind = EV_BREAK;
                    res.last       = 1'b1;
                end else if (i_rx_byte == CH_START) begin
                    n_sum   = 8'd0;
                    n_kept  = '0;
                    n_ovf   = 1'b0;
                    n_high  = 5'd0;
                    n_phase = PH_BODY;
                end
            end
        endcase

        // keep the decoded byte while the buffer has room
        if (keep_req) begin
            if (r_kept < KEEP_LIMIT) begin
                n_kept           = r_kept + 1'b1;
                res_valid        = 1'b1;
                res.payload_byte = keep_byte;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    // output buffer steering
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (accept && res_valid) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (accept && res_valid) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_sum        <= 8'd0;
            r_high       <= 5'd0;
            r_kept       <= '0;
            r_ovf        <= 1'b0;
            r_no_ack     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_sum   <= n_sum;
                r_high  <= n_high;
                r_kept  <= n_kept;
                r_ovf   <= n_ovf;
            end
            if (i_cfg_wr_en) begin
                r_no_ack <= i_cfg_wr_data;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid          = r_out_valid;
    assign o_event_kind     = r_out.event_kind;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_checksum_good  = r_out.checksum_good;
    assign o_reply_ack      = r_out.reply_ack;
    assign o_payload_length = r_out.payload_length;
    assign o_truncated      = r_out.truncated;
    assign o_last           = r_out.last;

endmodule

// ===== rtl/dpd_checker.sv =====
// ----------------------------------------------------------------------------
// dpd_checker
// Port-level checks for the debug link packet deframer, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpd_checker
    import dpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [1:0]  o_event_kind,
    input  logic [7:0]  o_payload_byte,
    input  logic        o_checksum_good,
    input  logic [1:0]  o_reply_ack,
    input  logic        o_last
);

    // no result word right after reset
    `DPD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "result word valid after reset")

    // a stalled result word holds
    `DPD_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_event_kind) && $stable(o_payload_byte), "stalled result word changed")

    // last marks exactly packet end and break words
    `DPD_ASSERT(a_last_kind, o_valid |-> (o_last == (o_event_kind != EV_PAYLOAD)), "last does not match word kind")

    // a negative ack goes with a bad checksum and only at packet end
    `DPD_ASSERT(a_nak_verdict, o_valid && o_reply_ack == ACK_NEG |-> o_event_kind == EV_END && !o_checksum_good, "negative ack without bad checksum")

    // a bad checksum at packet end always asks for a resend
    `DPD_ASSERT(a_bad_sum_nak, o_valid && o_event_kind == EV_END && !o_checksum_good |-> o_reply_ack == ACK_NEG, "bad checksum without negative ack")

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (.*);
